@@ design/bit_timed_serial_frame_receiver_defines.svh @@
// Assertion macros shared by the serial frame receiver checker.
// No dependencies; pulled in by `include where assertions are written.
`ifndef BIT_TIMED_SERIAL_FRAME_RECEIVER_DEFINES_SVH
`define BIT_TIMED_SERIAL_FRAME_RECEIVER_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define BTSR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define BTSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/btsr_pkg.sv @@
// Package for the bit-timed serial frame receiver: payload structs, phase
// enum, frame constants and register addresses. No dependencies.
package btsr_pkg;

  localparam int DATA_BITS = 16;   // data bits sampled per frame
  localparam int GAP_BITS  = 2;    // bit periods between stop and next start
  localparam int FRAME_W   = 16;   // bits kept in frame_data
  localparam int IDX_W     = 5;    // bit_index width
  localparam int TICK_W    = 16;
  localparam int SEL_W     = $clog2(FRAME_W);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_BIT_TICKS      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_HALF_BIT_TICKS = 3'd4;

  localparam logic [TICK_W-1:0] BIT_TICKS_RST      = 16'd16;
  localparam logic [TICK_W-1:0] HALF_BIT_TICKS_RST = 16'd8;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_DATA,
    PH_STOP,
    PH_GAP
  } phase_t;

  typedef struct packed {
    logic trigger_line;
    logic data_line;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_data;
    logic               start_level;
    logic               stop_level;
    logic               framing_error;
    logic               last_of_packet;
  } out_item_t;

endpackage

@@ design/bit_timed_serial_frame_receiver.sv @@
// Bit-timed serial frame receiver: one line sample per word, two 16-bit frames
// per packet, APB-style register port. Depends on btsr_pkg.
// A word is registered, then processed; its frame (if any) is registered for
// out_valid. Throughput: one word per cycle, set by the single input register
// feeding state update and result register, unless a frame waits on out_stall.
// Reset (rst_n low, synchronous): idle phase, empty pipeline, bit_ticks 16,
// half_bit_ticks 8.
module bit_timed_serial_frame_receiver
  import btsr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [TICK_W-1:0] bit_ticks_r, half_bit_ticks_r;
  logic              cfg_wr;

  logic              in_valid_r;
  in_item_t          in_r;

  phase_t            phase_r, phase_nxt, samp_phase;
  logic [TICK_W-1:0] tick_count_r, tick_count_nxt, tick_dec, period;
  logic [IDX_W-1:0]  bit_index_r, bit_index_nxt, idx_inc;
  logic [FRAME_W-1:0] shift_word_r, shift_word_nxt;
  logic              start_seen_r, start_seen_nxt;
  logic              frame_number_r, frame_number_nxt;

  logic              do_sample, take_start, produce, out_free, proceed;
  logic              out_valid_r;
  out_item_t         out_r, out_nxt;

  // ---------------- register port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (cfg_paddr)
      CFG_ADDR_BIT_TICKS:      cfg_prdata = CFG_DATA_W'(bit_ticks_r);
      CFG_ADDR_HALF_BIT_TICKS: cfg_prdata = CFG_DATA_W'(half_bit_ticks_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_ticks_r      <= BIT_TICKS_RST;
      half_bit_ticks_r <= HALF_BIT_TICKS_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr == CFG_ADDR_BIT_TICKS)
        bit_ticks_r <= cfg_pwdata[TICK_W-1:0];
      else if (cfg_paddr == CFG_ADDR_HALF_BIT_TICKS)
        half_bit_ticks_r <= cfg_pwdata[TICK_W-1:0];
    end
  end

  // ---------------- sample logic ----------------
  assign period   = (bit_ticks_r == '0) ? TICK_W'(1) : bit_ticks_r;
  assign tick_dec = tick_count_r - TICK_W'(tick_count_r != '0);
  assign idx_inc  = bit_index_r + IDX_W'(1);

  always_comb begin
    phase_nxt        = phase_r;
    tick_count_nxt   = tick_count_r;
    bit_index_nxt    = bit_index_r;
    shift_word_nxt   = shift_word_r;
    start_seen_nxt   = start_seen_r;
    frame_number_nxt = frame_number_r;
    samp_phase       = phase_r;
    do_sample        = 1'b0;
    take_start       = 1'b0;
    produce          = 1'b0;

    if (phase_r == PH_IDLE) begin
      samp_phase = PH_START;
      if (!in_r.trigger_line) begin
        phase_nxt        = PH_START;
        frame_number_nxt = 1'b0;
        tick_count_nxt   = half_bit_ticks_r;
        do_sample        = (half_bit_ticks_r == '0);
      end
    end else begin
      tick_count_nxt = tick_dec;
      do_sample      = (tick_dec == '0);
    end

    if (do_sample) begin
      unique case (samp_phase)
        PH_START: take_start = 1'b1;
        PH_DATA: begin
          if (bit_index_r < IDX_W'(FRAME_W))
            shift_word_nxt[bit_index_r[SEL_W-1:0]] = in_r.data_line;
          if (({1'b0, bit_index_r} + (IDX_W+1)'(1)) >= (IDX_W+1)'(DATA_BITS))
            phase_nxt = PH_STOP;
          else
            bit_index_nxt = idx_inc;
          tick_count_nxt = period;
        end
        PH_STOP: begin
          produce = 1'b1;
          bit_index_nxt = '0;
          if (!frame_number_r) begin
            frame_number_nxt = 1'b1;
            phase_nxt        = PH_GAP;
            tick_count_nxt   = period;
          end else begin
            frame_number_nxt = 1'b0;
            phase_nxt        = PH_IDLE;
            tick_count_nxt   = '0;
          end
        end
        PH_GAP: begin
          bit_index_nxt = idx_inc;
          // gap of zero bits still waits one bit period
          if (idx_inc >= IDX_W'(GAP_BITS))
            take_start = 1'b1;
          else
            tick_count_nxt = period;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end

    if (take_start) begin
      start_seen_nxt = in_r.data_line;
      shift_word_nxt = '0;
      bit_index_nxt  = '0;
      phase_nxt      = PH_DATA;
      tick_count_nxt = period;
    end

    out_nxt.frame_data     = shift_word_r;
    out_nxt.start_level    = start_seen_r;
    out_nxt.stop_level     = in_r.data_line;
    out_nxt.framing_error  = start_seen_r || !in_r.data_line;
    out_nxt.last_of_packet = frame_number_r;
  end

  // ---------------- flow control ----------------
  assign out_free = !out_valid_r || !out_stall;
  assign proceed  = in_valid_r && (!produce || out_free);
  assign in_stall = in_valid_r && !proceed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (proceed) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall)
      in_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      tick_count_r   <= '0;
      bit_index_r    <= '0;
      shift_word_r   <= '0;
      start_seen_r   <= 1'b0;
      frame_number_r <= 1'b0;
    end else if (proceed) begin
      phase_r        <= phase_nxt;
      tick_count_r   <= tick_count_nxt;
      bit_index_r    <= bit_index_nxt;
      shift_word_r   <= shift_word_nxt;
      start_seen_r   <= start_seen_nxt;
      frame_number_r <= frame_number_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proceed && produce) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && produce)
      out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ design/btsr_checker.sv @@
// Port-level checker for the serial frame receiver, bound to the top level.
// Depends on btsr_pkg and bit_timed_serial_frame_receiver_defines.svh.
`include "bit_timed_serial_frame_receiver_defines.svh"

module btsr_checker
  import btsr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data,
  input logic      cfg_pready
);

  `BTSR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result word changed")
  `BTSR_ASSERT_IMPL(a_frm_err, clk, rst_n, out_valid, out_data.framing_error == (out_data.start_level || !out_data.stop_level), "framing_error inconsistent with start/stop levels")
  `BTSR_ASSERT_IMPL(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without a blocked result")
  `BTSR_ASSERT_IMPL(a_pready, clk, rst_n, 1'b1, cfg_pready, "register port not ready")

endmodule

bind bit_timed_serial_frame_receiver btsr_checker u_btsr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_data   (out_data),
  .cfg_pready (cfg_pready)
);
